// File: design/amcn_pkg.sv
// ----------------------------------------------------------------------------
// amcn_pkg: shared types and constants of the min/max calibrating normalizer
// Sample width, derived datapath widths, register indexes, FSM states and the
// status record of the serial divider.
// ----------------------------------------------------------------------------
package amcn_pkg;

  localparam int SAMPLE_BITS = 20;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int OUT_W      = 8;

  // |v - min| fits SAMPLE_BITS bits, |out_high - out_low| fits OUT_W bits.
  localparam int MAG_W    = SAMPLE_BITS + OUT_W;
  // The divider retires two quotient bits per cycle, so the numerator is even.
  localparam int NUM_W    = 2 * ((MAG_W + 1) / 2);
  localparam int DEN_W    = SAMPLE_BITS;
  localparam int SUM_W    = NUM_W + 2;
  localparam int DIV_ITER = NUM_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [TIME_W-1:0]       CALIB_MS_RESET = 32'd30000;
  localparam logic signed [OUT_W-1:0] OUT_LOW_RESET  = -8'sd1;
  localparam logic signed [OUT_W-1:0] OUT_HIGH_RESET = 8'sd1;

  localparam logic [CFG_IDX_W-1:0] REG_CALIB_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH = 2'd2;

  localparam int NUM_AXES = 3;
  typedef logic [1:0] axis_idx_t;
  localparam axis_idx_t LAST_AXIS = axis_idx_t'(NUM_AXES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: design/amcn_div.sv
// ----------------------------------------------------------------------------
// amcn_div: serial unsigned restoring divider
// Shifts the numerator through a remainder register two bits per cycle and
// shifts the quotient bits in behind it; pulses done when the quotient is set.
// ----------------------------------------------------------------------------
module amcn_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [amcn_pkg::NUM_W-1:0] numer,
  input  logic [amcn_pkg::DEN_W-1:0] denom,
  output amcn_pkg::div_stat_t       stat,
  output logic [amcn_pkg::NUM_W-1:0] quot
);
  import amcn_pkg::*;

  logic [NUM_W-1:0]     work;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic [DIV_CNT_W-1:0] cnt;

  logic [DEN_W:0]   r1, r2;
  logic             ge1, ge2;
  logic [DEN_W-1:0] rem1, rem2;
  logic [NUM_W-1:0] w1, w2;

  always_comb begin
    r1   = {rem, work[NUM_W-1]};
    ge1  = r1 >= {1'b0, den};
    rem1 = ge1 ? DEN_W'(r1 - {1'b0, den}) : DEN_W'(r1);
    w1   = {work[NUM_W-2:0], ge1};
    r2   = {rem1, w1[NUM_W-1]};
    ge2  = r2 >= {1'b0, den};
    rem2 = ge2 ? DEN_W'(r2 - {1'b0, den}) : DEN_W'(r2);
    w2   = {w1[NUM_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        work      <= numer;
        rem       <= '0;
        den       <= denom;
        cnt       <= DIV_CNT_W'(DIV_ITER);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        work <= w2;
        rem  <= rem2;
        cnt  <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  assign quot = work;

  ap_busy_counts: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> cnt != '0)
    else $error("divider busy with an exhausted step counter");

endmodule

// File: design/axis_minmax_calibrate_normalize_top.sv
// ----------------------------------------------------------------------------
// axis_minmax_calibrate_normalize_top: three-axis min/max calibrating normalizer
// Tracks per-axis extremes over a calibration window, then maps each axis
// linearly from its calibrated range to a configured output range.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Beat contents
//  -------   --------------------------   ------------------------------------
//  config    cfg_write                    cfg_index, cfg_data
//  sample    sample_valid / sample_stall  sample_x/y/z, time_ms
//  result    result_valid / result_stall  phase, just_finished, out_x/y/z,
//                                         min/max per axis, samples_seen
//
// A calibration beat passes through ST_CAL and ST_OUT to a loaded result.
// A mapped beat passes through ST_MUL and ST_DIV once per axis, then ST_OUT:
// the three axes share one serial divider that retires two quotient bits per
// cycle; each axis's add and saturate is combinational on the quotient and is
// stored in the result when the divider finishes.
// Reset is synchronous and restores the configuration defaults and the
// calibration state; no clearing pass is needed.
// The output register holds a result under result_stall; the next result then
// waits in ST_OUT, and no new sample is accepted until it is loaded.
// ----------------------------------------------------------------------------
module axis_minmax_calibrate_normalize_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [amcn_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [amcn_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic signed [amcn_pkg::SAMPLE_BITS-1:0] sample_x,
  input  logic signed [amcn_pkg::SAMPLE_BITS-1:0] sample_y,
  input  logic signed [amcn_pkg::SAMPLE_BITS-1:0] sample_z,
  input  logic [amcn_pkg::TIME_W-1:0]             time_ms,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic                                   phase,
  output logic                                   just_finished,
  output logic signed [amcn_pkg::SAMPLE_BITS-1:0] out_x,
  output logic signed [amcn_pkg::SAMPLE_BITS-1:0] out_y,
  output logic signed [amcn_pkg::SAMPLE_BITS-1:0] out_z,
  output logic signed [amcn_pkg::SAMPLE_BITS-1:0] min_x,
  output logic signed [amcn_pkg::SAMPLE_BITS-1:0] max_x,
  output logic signed [amcn_pkg::SAMPLE_BITS-1:0] min_y,
  output logic signed [amcn_pkg::SAMPLE_BITS-1:0] max_y,
  output logic signed [amcn_pkg::SAMPLE_BITS-1:0] min_z,
  output logic signed [amcn_pkg::SAMPLE_BITS-1:0] max_z,
  output logic [amcn_pkg::COUNT_W-1:0]            samples_seen
);
  import amcn_pkg::*;

  localparam int SB = SAMPLE_BITS;

  state_t state, state_next;

  // Configuration registers.
  logic [TIME_W-1:0]       calibration_ms;
  logic signed [OUT_W-1:0] out_low;
  logic signed [OUT_W-1:0] out_high;

  // Calibration state.
  logic signed [SB-1:0] axis_min [NUM_AXES];
  logic signed [SB-1:0] axis_max [NUM_AXES];
  logic [COUNT_W-1:0]   calib_count;
  logic                 in_calibration;
  logic [TIME_W-1:0]    window_start;
  logic                 start_latched;

  // The accepted sample and its pending result.
  logic signed [SB-1:0] smp [NUM_AXES];
  logic [TIME_W-1:0]    smp_time;
  logic signed [SB-1:0] res [NUM_AXES];
  logic                 res_phase;
  logic                 res_done;
  axis_idx_t            axis;
  logic                 neg_q;
  logic                 zero_rng;

  logic             div_start;
  div_stat_t        div_stat;
  logic [NUM_W-1:0] div_numer;
  logic [NUM_W-1:0] div_quot;
  logic [DEN_W-1:0] div_denom;

  logic load_out;
  assign load_out = (state == ST_OUT) && (!result_valid || !result_stall);

  // Elapsed time is taken modulo 2^32; the first sample opens the window.
  logic [TIME_W-1:0] elapsed;
  logic              cal_done;
  assign elapsed  = smp_time - (start_latched ? window_start : smp_time);
  assign cal_done = elapsed >= calibration_ms;

  // Multiply the magnitudes; the sign of the quotient is kept aside.
  logic signed [SB:0]      diff;
  logic signed [OUT_W:0]   delta;
  logic [SB-1:0]           diff_mag;
  logic [OUT_W-1:0]        delta_mag;
  logic [MAG_W-1:0]        prod;

  always_comb begin
    diff      = (SB+1)'(smp[axis]) - (SB+1)'(axis_min[axis]);
    delta     = (OUT_W+1)'(out_high) - (OUT_W+1)'(out_low);
    diff_mag  = SB'(diff[SB] ? -diff : diff);
    delta_mag = OUT_W'(delta[OUT_W] ? -delta : delta);
    prod      = MAG_W'(diff_mag) * MAG_W'(delta_mag);
    div_numer = NUM_W'(prod);
    div_denom = DEN_W'(axis_max[axis] - axis_min[axis]);
  end

  // Apply the sign, add out_low, saturate to the field; a zero range gives zero.
  logic [SUM_W-1:0]        q_ext;
  logic signed [SUM_W-1:0] q_signed;
  logic signed [SUM_W-1:0] sum;
  logic signed [SB-1:0]    mapped;

  always_comb begin
    q_ext    = SUM_W'(div_quot);
    q_signed = neg_q ? -$signed(q_ext) : $signed(q_ext);
    sum      = q_signed + SUM_W'(out_low);
    if (zero_rng) begin
      mapped = '0;
    end else if (sum > SUM_W'(SAMPLE_MAX)) begin
      mapped = SAMPLE_MAX;
    end else if (sum < SUM_W'(SAMPLE_MIN)) begin
      mapped = SAMPLE_MIN;
    end else begin
      mapped = SB'(sum);
    end
  end

  amcn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_stall = 1'b1;
    div_start    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          state_next = in_calibration ? ST_CAL : ST_MUL;
        end
      end
      ST_CAL: begin
        state_next = ST_OUT;
      end
      ST_MUL: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = (axis == LAST_AXIS) ? ST_OUT : ST_MUL;
        end
      end
      ST_OUT: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control and calibration state.
  always_ff @(posedge clk) begin
    if (rst) begin
      calibration_ms <= CALIB_MS_RESET;
      out_low        <= OUT_LOW_RESET;
      out_high       <= OUT_HIGH_RESET;
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_min[i] <= SAMPLE_MAX;
        axis_max[i] <= SAMPLE_MIN;
      end
      calib_count    <= '0;
      in_calibration <= 1'b1;
      window_start   <= '0;
      start_latched  <= 1'b0;
      result_valid   <= 1'b0;
      axis           <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_CALIB_MS: calibration_ms <= TIME_W'(cfg_data);
          REG_OUT_LOW:  out_low        <= OUT_W'(cfg_data);
          REG_OUT_HIGH: out_high       <= OUT_W'(cfg_data);
          default: ;
        endcase
      end

      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          axis <= '0;
        end
        ST_CAL: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            if (smp[i] < axis_min[i]) axis_min[i] <= smp[i];
            if (smp[i] > axis_max[i]) axis_max[i] <= smp[i];
          end
          calib_count <= calib_count + COUNT_W'(1);
          if (!start_latched) begin
            window_start  <= smp_time;
            start_latched <= 1'b1;
          end
          if (cal_done) begin
            in_calibration <= 1'b0;
          end
        end
        ST_DIV: begin
          if (div_stat.done && axis != LAST_AXIS) begin
            axis <= axis + axis_idx_t'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Sample, working and result payload.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample_valid) begin
      smp[0]   <= sample_x;
      smp[1]   <= sample_y;
      smp[2]   <= sample_z;
      smp_time <= time_ms;
    end
    if (state == ST_CAL) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        res[i] <= smp[i];
      end
      res_phase <= 1'b0;
      res_done  <= cal_done;
    end
    if (state == ST_MUL) begin
      neg_q    <= diff[SB] ^ delta[OUT_W];
      zero_rng <= axis_max[axis] == axis_min[axis];
    end
    if (state == ST_DIV && div_stat.done) begin
      res[axis] <= mapped;
      res_phase <= 1'b1;
      res_done  <= 1'b0;
    end
    if (load_out) begin
      phase         <= res_phase;
      just_finished <= res_done;
      out_x         <= res[0];
      out_y         <= res[1];
      out_z         <= res[2];
      min_x         <= axis_min[0];
      max_x         <= axis_max[0];
      min_y         <= axis_min[1];
      max_y         <= axis_max[1];
      min_z         <= axis_min[2];
      max_z         <= axis_max[2];
      samples_seen  <= calib_count;
    end
  end

  ap_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_OUT))
    else $error("result loaded outside the output state");

  ap_calib_sticky: assert property (@(posedge clk) disable iff (rst)
    !in_calibration |=> !in_calibration)
    else $error("calibration restarted without reset");

  ap_range_order: assert property (@(posedge clk) disable iff (rst)
    (calib_count != '0) |-> (axis_min[0] <= axis_max[0] && axis_min[1] <= axis_max[1]
                             && axis_min[2] <= axis_max[2]))
    else $error("calibrated minimum above maximum");

  ap_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished while no axis was waiting for it");

endmodule
